@@ rtl/rqi_pkg.sv @@
// Shared constants, types and fixed-point helpers of the ray/quadric intersect unit.
package rqi_pkg;

  // Fixed-point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int SAT_W     = 72;
  localparam int CFG_IDX_W = 4;
  localparam int SQ_STG    = 32;              // one root bit per stage, 64-bit radicand
  localparam int MAG_W     = 34;              // |-b +- sqrt(disc)| < 2^34
  localparam int NUMW      = MAG_W + FRAC_BITS;
  localparam int DEN_W     = 33;              // |2a| <= 2^32

  localparam logic signed [DATA_W-1:0] ONE_FX   = DATA_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] CLIP_RST = DATA_W'((64'sd95 * (64'sd1 <<< FRAC_BITS)) / 100);

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sd2147483648);

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_CENTER_Z = 4'd2,
    REG_COEF_X   = 4'd3,
    REG_COEF_Y   = 4'd4,
    REG_COEF_Z   = 4'd5,
    REG_COEF_K   = 4'd6,
    REG_CLIP_Z   = 4'd7
  } cfg_reg_e;

  // Sideband that rides along the square-root pipeline
  typedef struct packed {
    logic                   vld;
    logic                   miss;
    logic [2:0][DATA_W-1:0] st;
    logic [2:0][DATA_W-1:0] dir;
    logic [DATA_W-1:0]      a;
    logic [DATA_W-1:0]      b;
  } sq_sb_t;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic                   vld;
    logic                   miss;
    logic                   sg1;
    logic                   sg2;
    logic [2:0][DATA_W-1:0] st;
    logic [2:0][DATA_W-1:0] dir;
  } div_sb_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Floor-shift a raw product back to the fixed-point format and clamp
  function automatic logic signed [DATA_W-1:0] fx_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return sat32(SAT_W'(s));
  endfunction

endpackage

@@ rtl/rqi_if.sv @@
// Request channels of the ray/quadric intersect unit: configuration, ray and hit.
interface rqi_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [rqi_pkg::CFG_IDX_W-1:0]          index;
  logic [rqi_pkg::DATA_W-1:0]             data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface rqi_ray_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rqi_pkg::DATA_W-1:0]      start_x;
  logic signed [rqi_pkg::DATA_W-1:0]      start_y;
  logic signed [rqi_pkg::DATA_W-1:0]      start_z;
  logic signed [rqi_pkg::DATA_W-1:0]      dir_x;
  logic signed [rqi_pkg::DATA_W-1:0]      dir_y;
  logic signed [rqi_pkg::DATA_W-1:0]      dir_z;
  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rqi_hit_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit_found;
  logic signed [rqi_pkg::DATA_W-1:0]      hit_dist;
  logic signed [rqi_pkg::DATA_W-1:0]      pos_x;
  logic signed [rqi_pkg::DATA_W-1:0]      pos_y;
  logic signed [rqi_pkg::DATA_W-1:0]      pos_z;
  logic signed [rqi_pkg::DATA_W-1:0]      norm_x;
  logic signed [rqi_pkg::DATA_W-1:0]      norm_y;
  logic signed [rqi_pkg::DATA_W-1:0]      norm_z;
  modport source (output valid, hit_found, hit_dist, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, input ready);
  modport sink   (input valid, hit_found, hit_dist, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, output ready);
endinterface

@@ rtl/rqi_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, 64-bit radicand.
module rqi_sqrt_pipe (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [63:0] v_in [rqi_pkg::SQ_STG];
  logic [63:0] r_in [rqi_pkg::SQ_STG];
  logic [63:0] v_q  [rqi_pkg::SQ_STG];
  logic [63:0] r_q  [rqi_pkg::SQ_STG];

  assign v_in[0] = rad_i;
  assign r_in[0] = '0;

  for (genvar k = 0; k < rqi_pkg::SQ_STG; k++) begin : g_stg
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;
    logic [63:0] v_d;
    logic [63:0] r_d;

    if (k > 0) begin : g_link
      assign v_in[k] = v_q[k-1];
      assign r_in[k] = r_q[k-1];
    end

    // Trial subtract of the next root bit
    always_comb begin
      trial = r_in[k] + BIT;
      take  = (v_in[k] >= trial);
      v_d   = take ? (v_in[k] - trial) : v_in[k];
      r_d   = take ? ((r_in[k] >> 1) + BIT) : (r_in[k] >> 1);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= v_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign root_o = r_q[rqi_pkg::SQ_STG-1][31:0];

endmodule

@@ rtl/rqi_div_pipe.sv @@
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module rqi_div_pipe (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rqi_pkg::NUMW-1:0]      num_i,
  input  logic [rqi_pkg::DEN_W-1:0]     den_i,
  output logic [rqi_pkg::NUMW-1:0]      quo_o
);

  localparam int NW = rqi_pkg::NUMW;
  localparam int DW = rqi_pkg::DEN_W;

  logic [NW-1:0] n_in [NW];
  logic [DW-1:0] r_in [NW];
  logic [DW-1:0] d_in [NW];
  logic [NW-1:0] n_q  [NW];
  logic [DW-1:0] r_q  [NW];
  logic [DW-1:0] d_q  [NW];

  assign n_in[0] = num_i;
  assign r_in[0] = '0;
  assign d_in[0] = den_i;

  for (genvar k = 0; k < NW; k++) begin : g_stg
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (k > 0) begin : g_link
      assign n_in[k] = n_q[k-1];
      assign r_in[k] = r_q[k-1];
      assign d_in[k] = d_q[k-1];
    end

    // Shift in the next numerator bit and try the subtract
    always_comb begin
      trial = {r_in[k], n_in[k][NW-1]};
      diff  = trial - {1'b0, d_in[k]};
      take  = (trial >= {1'b0, d_in[k]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
        n_q[k] <= {n_in[k][NW-2:0], take};
        d_q[k] <= d_in[k];
      end
    end
  end

  assign quo_o = n_q[NW-1];

endmodule

@@ rtl/ray_quadric_intersect_unit.sv @@
// Top level of the ray/quadric intersect unit: fixed-point quadric hit pipeline.
//
// Usage:
//   cfg_i  : register writes (index, data), always ready; write only while the
//            pipeline is empty. Index 0..7 selects center xyz, coef xyz, the
//            constant term and the clip height; other indexes are dropped.
//   ray_i  : one ray request (origin, direction) per accepted cycle.
//   hit_o  : one hit request per ray, in order: hit flag, distance, position,
//            gradient normal; all fields are zero on a miss.
// Throughput: one ray per cycle while the output is not stalled.
// Pipeline: 8 stages forming the quadratic and discriminant, 32 square-root
//   stages, one numerator stage, 34 + FRAC_BITS divider stages for the Q16.16
//   quotient, 5 stages for position, clip and normal, and the output register.
// Stall: the whole pipeline advances only while the output register is empty
//   or taken; ray_i.ready drops while a finished result is held, so nothing
//   is lost or repeated.
// Reset: all valid bits clear and the registers return to the unit sphere
//   with clip height 0.95.
module ray_quadric_intersect_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  rqi_cfg_if.sink      cfg_i,
  rqi_ray_if.sink      ray_i,
  rqi_hit_if.source    hit_o
);

  localparam int F  = rqi_pkg::FRAC_BITS;
  localparam int DW = rqi_pkg::DATA_W;
  localparam int SW = rqi_pkg::SAT_W;
  localparam int NW = rqi_pkg::NUMW;
  localparam int QS = rqi_pkg::SQ_STG;

  // Configuration registers
  logic signed [DW-1:0] center_q [3];
  logic signed [DW-1:0] coef_q   [3];
  logic signed [DW-1:0] kconst_q;
  logic signed [DW-1:0] clip_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      coef_q[0]   <= rqi_pkg::ONE_FX;
      coef_q[1]   <= rqi_pkg::ONE_FX;
      coef_q[2]   <= rqi_pkg::ONE_FX;
      kconst_q    <= -rqi_pkg::ONE_FX;
      clip_q      <= rqi_pkg::CLIP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rqi_pkg::REG_CENTER_X: center_q[0] <= cfg_i.data;
        rqi_pkg::REG_CENTER_Y: center_q[1] <= cfg_i.data;
        rqi_pkg::REG_CENTER_Z: center_q[2] <= cfg_i.data;
        rqi_pkg::REG_COEF_X:   coef_q[0]   <= cfg_i.data;
        rqi_pkg::REG_COEF_Y:   coef_q[1]   <= cfg_i.data;
        rqi_pkg::REG_COEF_Z:   coef_q[2]   <= cfg_i.data;
        rqi_pkg::REG_COEF_K:   kconst_q    <= cfg_i.data;
        rqi_pkg::REG_CLIP_Z:   clip_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a result waits
  logic out_vld_q;
  logic en;
  assign en          = !out_vld_q || hit_o.ready;
  assign ray_i.ready = en;

  logic signed [DW-1:0] in_st [3];
  logic signed [DW-1:0] in_d  [3];
  assign in_st[0] = ray_i.start_x;
  assign in_st[1] = ray_i.start_y;
  assign in_st[2] = ray_i.start_z;
  assign in_d[0]  = ray_i.dir_x;
  assign in_d[1]  = ray_i.dir_y;
  assign in_d[2]  = ray_i.dir_z;

  // Front valid chain, stages 1..7
  logic [6:0] fv_q;

  // Front payload
  logic signed [DW-1:0] s1_st_q [3], s1_d_q [3], s1_s_q [3];
  logic signed [63:0]   s2_dd_q [3], s2_ds_q [3], s2_ss_q [3];
  logic signed [DW-1:0] s2_st_q [3], s2_d_q [3];
  logic signed [DW-1:0] s3_dd_q [3], s3_ds_q [3], s3_ss_q [3];
  logic signed [DW-1:0] s3_st_q [3], s3_d_q [3];
  logic signed [63:0]   s4_pa_q [3], s4_pb_q [3], s4_pc_q [3];
  logic signed [DW-1:0] s4_st_q [3], s4_d_q [3];
  logic signed [DW-1:0] s5_fa_q [3], s5_fb_q [3], s5_fc_q [3];
  logic signed [DW-1:0] s5_st_q [3], s5_d_q [3];
  logic signed [DW-1:0] s6_a_q, s6_b_q, s6_c_q;
  logic signed [DW-1:0] s6_st_q [3], s6_d_q [3];
  logic signed [63:0]   s7_bb_q, s7_ac_q;
  logic signed [DW-1:0] s7_a_q, s7_b_q;
  logic signed [DW-1:0] s7_st_q [3], s7_d_q [3];
  logic [63:0]          s8_rad_q;

  logic signed [SW-1:0] sum_a, sum_b, sum_c;
  logic signed [64:0]   qv;

  always_comb begin
    sum_a = SW'(s5_fa_q[0]) + SW'(s5_fa_q[1]) + SW'(s5_fa_q[2]);
    sum_b = SW'(s5_fb_q[0]) + SW'(s5_fb_q[1]) + SW'(s5_fb_q[2]);
    sum_c = SW'(s5_fc_q[0]) + SW'(s5_fc_q[1]) + SW'(s5_fc_q[2]) + SW'(kconst_q);
    qv    = 65'(s7_bb_q >>> 2) - 65'(s7_ac_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // offset from the center
        s1_st_q[i] <= in_st[i];
        s1_d_q[i]  <= in_d[i];
        s1_s_q[i]  <= rqi_pkg::sat32(SW'(in_st[i]) - SW'(center_q[i]));
        // raw squares and cross products
        s2_dd_q[i] <= 64'(s1_d_q[i]) * 64'(s1_d_q[i]);
        s2_ds_q[i] <= 64'(s1_d_q[i]) * 64'(s1_s_q[i]);
        s2_ss_q[i] <= 64'(s1_s_q[i]) * 64'(s1_s_q[i]);
        s2_st_q[i] <= s1_st_q[i];
        s2_d_q[i]  <= s1_d_q[i];
        s3_dd_q[i] <= rqi_pkg::fx_sat(s2_dd_q[i]);
        s3_ds_q[i] <= rqi_pkg::fx_sat(s2_ds_q[i]);
        s3_ss_q[i] <= rqi_pkg::fx_sat(s2_ss_q[i]);
        s3_st_q[i] <= s2_st_q[i];
        s3_d_q[i]  <= s2_d_q[i];
        // coefficient weighting
        s4_pa_q[i] <= 64'(coef_q[i]) * 64'(s3_dd_q[i]);
        s4_pb_q[i] <= 64'(coef_q[i]) * 64'(s3_ds_q[i]);
        s4_pc_q[i] <= 64'(coef_q[i]) * 64'(s3_ss_q[i]);
        s4_st_q[i] <= s3_st_q[i];
        s4_d_q[i]  <= s3_d_q[i];
        s5_fa_q[i] <= rqi_pkg::fx_sat(s4_pa_q[i]);
        s5_fb_q[i] <= rqi_pkg::fx_sat(s4_pb_q[i]);
        s5_fc_q[i] <= rqi_pkg::fx_sat(s4_pc_q[i]);
        s5_st_q[i] <= s4_st_q[i];
        s5_d_q[i]  <= s4_d_q[i];
        s6_st_q[i] <= s5_st_q[i];
        s6_d_q[i]  <= s5_d_q[i];
        s7_st_q[i] <= s6_st_q[i];
        s7_d_q[i]  <= s6_d_q[i];
      end
      // quadratic coefficients
      s6_a_q   <= rqi_pkg::sat32(sum_a);
      s6_b_q   <= rqi_pkg::sat32(sum_b <<< 1);
      s6_c_q   <= rqi_pkg::sat32(sum_c);
      // quarter discriminant products
      s7_bb_q  <= 64'(s6_b_q) * 64'(s6_b_q);
      s7_ac_q  <= 64'(s6_a_q) * 64'(s6_c_q);
      s7_a_q   <= s6_a_q;
      s7_b_q   <= s6_b_q;
      s8_rad_q <= qv[63:0];
    end
  end

  // Stage 8 sideband and the square-root delay line
  rqi_pkg::sq_sb_t s8_sb_d, s8_sb_q;
  rqi_pkg::sq_sb_t sq_sb_q [QS];

  always_comb begin
    s8_sb_d.vld  = fv_q[6];
    s8_sb_d.miss = (s7_a_q == '0) || qv[64];
    for (int i = 0; i < 3; i++) begin
      s8_sb_d.st[i]  = s7_st_q[i];
      s8_sb_d.dir[i] = s7_d_q[i];
    end
    s8_sb_d.a = s7_a_q;
    s8_sb_d.b = s7_b_q;
  end

  logic [31:0] root;

  rqi_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s8_rad_q),
    .root_o (root)
  );

  // Numerator stage: -b +- sqrt(disc), signs and magnitudes
  rqi_pkg::sq_sb_t      sq_out;
  logic signed [34:0]   nb, sd, n1, n2, n1_abs, n2_abs;
  logic signed [32:0]   a_abs;
  rqi_pkg::div_sb_t     n_sb_d, n_sb_q;
  logic [NW-1:0]        n_num1_q, n_num2_q;
  logic [rqi_pkg::DEN_W-1:0] n_den_q;

  assign sq_out = sq_sb_q[QS-1];

  always_comb begin
    nb     = -35'($signed(sq_out.b));
    sd     = $signed({2'b00, root, 1'b0});
    n1     = nb + sd;
    n2     = nb - sd;
    n1_abs = n1[34] ? -n1 : n1;
    n2_abs = n2[34] ? -n2 : n2;
    a_abs  = sq_out.a[DW-1] ? -33'($signed(sq_out.a)) : 33'($signed(sq_out.a));
    n_sb_d.vld  = sq_out.vld;
    n_sb_d.miss = sq_out.miss;
    n_sb_d.sg1  = n1[34] ^ sq_out.a[DW-1];
    n_sb_d.sg2  = n2[34] ^ sq_out.a[DW-1];
    n_sb_d.st   = sq_out.st;
    n_sb_d.dir  = sq_out.dir;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_num1_q <= {n1_abs[rqi_pkg::MAG_W-1:0], {F{1'b0}}};
      n_num2_q <= {n2_abs[rqi_pkg::MAG_W-1:0], {F{1'b0}}};
      n_den_q  <= {a_abs[31:0], 1'b0};
    end
  end

  // Two dividers for the two roots
  logic [NW-1:0] quo1, quo2;
  rqi_pkg::div_sb_t dv_sb_q [NW];

  rqi_div_pipe u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n_num1_q),
    .den_i (n_den_q),
    .quo_o (quo1)
  );

  rqi_div_pipe u_div2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n_num2_q),
    .den_i (n_den_q),
    .quo_o (quo2)
  );

  // Sideband lines and valid bits
  logic [4:0] pv_q;
  rqi_pkg::div_sb_t dv_out;
  assign dv_out = dv_sb_q[NW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q    <= '0;
      s8_sb_q <= '0;
      n_sb_q  <= '0;
      pv_q    <= '0;
      for (int k = 0; k < QS; k++) sq_sb_q[k] <= '0;
      for (int k = 0; k < NW; k++) dv_sb_q[k] <= '0;
    end else if (en) begin
      fv_q    <= {fv_q[5:0], ray_i.valid};
      s8_sb_q <= s8_sb_d;
      sq_sb_q[0] <= s8_sb_q;
      for (int k = 1; k < QS; k++) sq_sb_q[k] <= sq_sb_q[k-1];
      n_sb_q  <= n_sb_d;
      dv_sb_q[0] <= n_sb_q;
      for (int k = 1; k < NW; k++) dv_sb_q[k] <= dv_sb_q[k-1];
      pv_q    <= {pv_q[3:0], dv_out.vld};
    end
  end

  // Root select and distance
  logic signed [NW:0] t1, t2;
  logic               t1_pos, t2_pos;

  always_comb begin
    t1     = $signed({1'b0, quo1});
    t2     = $signed({1'b0, quo2});
    if (dv_out.sg1) t1 = -t1;
    if (dv_out.sg2) t2 = -t2;
    t1_pos = !dv_out.sg1 && (quo1 != '0);
    t2_pos = !dv_out.sg2 && (quo2 != '0);
  end

  // Back payload
  logic                 p1_miss_q, p2_miss_q, p3_miss_q, p4_miss_q, p5_miss_q;
  logic signed [DW-1:0] p1_dist_q, p2_dist_q, p3_dist_q, p4_dist_q, p5_dist_q;
  logic signed [DW-1:0] p1_st_q [3], p1_d_q [3], p2_st_q [3];
  logic signed [63:0]   p2_raw_q [3], p5_raw_q [3];
  logic signed [DW-1:0] p3_pos_q [3], p4_pos_q [3], p5_pos_q [3], p4_off_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_miss_q <= dv_out.miss || !t1_pos;
      p1_dist_q <= rqi_pkg::sat32(SW'(t2_pos ? t2 : t1));
      for (int i = 0; i < 3; i++) begin
        p1_st_q[i] <= $signed(dv_out.st[i]);
        p1_d_q[i]  <= $signed(dv_out.dir[i]);
        // step along the ray
        p2_raw_q[i] <= 64'(p1_d_q[i]) * 64'(p1_dist_q);
        p2_st_q[i]  <= p1_st_q[i];
        p3_pos_q[i] <= rqi_pkg::sat32(SW'(p2_st_q[i]) + SW'(p2_raw_q[i] >>> F));
        p4_pos_q[i] <= p3_pos_q[i];
        p4_off_q[i] <= rqi_pkg::sat32(SW'(p3_pos_q[i]) - SW'(center_q[i]));
        p5_pos_q[i] <= p4_pos_q[i];
        p5_raw_q[i] <= 64'(coef_q[i]) * 64'(p4_off_q[i]);
      end
      p2_miss_q <= p1_miss_q;
      p2_dist_q <= p1_dist_q;
      p3_miss_q <= p2_miss_q;
      p3_dist_q <= p2_dist_q;
      // clip against the height limit
      p4_miss_q <= p3_miss_q || (p3_pos_q[2] > clip_q);
      p4_dist_q <= p3_dist_q;
      p5_miss_q <= p4_miss_q;
      p5_dist_q <= p4_dist_q;
    end
  end

  // Output register
  logic signed [DW-1:0] nrm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = rqi_pkg::sat32(SW'(rqi_pkg::fx_sat(p5_raw_q[i])) <<< 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pv_q[4];
    end
  end

  logic                 o_hit_q;
  logic signed [DW-1:0] o_dist_q, o_pos_q [3], o_nrm_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_hit_q  <= !p5_miss_q;
      o_dist_q <= p5_miss_q ? '0 : p5_dist_q;
      for (int i = 0; i < 3; i++) begin
        o_pos_q[i] <= p5_miss_q ? '0 : p5_pos_q[i];
        o_nrm_q[i] <= p5_miss_q ? '0 : nrm[i];
      end
    end
  end

  assign hit_o.valid     = out_vld_q;
  assign hit_o.hit_found = o_hit_q;
  assign hit_o.hit_dist  = o_dist_q;
  assign hit_o.pos_x     = o_pos_q[0];
  assign hit_o.pos_y     = o_pos_q[1];
  assign hit_o.pos_z     = o_pos_q[2];
  assign hit_o.norm_x    = o_nrm_q[0];
  assign hit_o.norm_y    = o_nrm_q[1];
  assign hit_o.norm_z    = o_nrm_q[2];

endmodule

@@ rtl/rqi_checker.sv @@
// Port-level assertions of the ray/quadric intersect unit and their bind.
module rqi_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             hit_found_i,
  input logic signed [rqi_pkg::DATA_W-1:0] hit_dist_i,
  input logic signed [rqi_pkg::DATA_W-1:0] pos_x_i,
  input logic signed [rqi_pkg::DATA_W-1:0] norm_z_i
);

  // A held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Ray intake follows the output stall
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("ray ready does not track output stall");

  // A miss carries a zeroed distance, x position and z normal
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_found_i |-> hit_dist_i == '0 && pos_x_i == '0 && norm_z_i == '0)
    else $error("miss with nonzero fields");

  // A hit lies strictly ahead of the origin
  a_hit_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_found_i |-> hit_dist_i > 0)
    else $error("hit with non-positive distance");

endmodule

bind ray_quadric_intersect_unit rqi_checker u_rqi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (ray_i.ready),
  .out_valid_i (hit_o.valid),
  .out_ready_i (hit_o.ready),
  .hit_found_i (hit_o.hit_found),
  .hit_dist_i  (hit_o.hit_dist),
  .pos_x_i     (hit_o.pos_x),
  .norm_z_i    (hit_o.norm_z)
);

@@ tb/ray_quadric_intersect_unit_test.sv @@
// Self-checking testbench of the ray/quadric intersect unit with a predicting scoreboard.
`timescale 1ns / 1ps

module ray_quadric_intersect_unit_test;

  localparam int  DW             = rqi_pkg::DATA_W;
  localparam int  FB             = rqi_pkg::FRAC_BITS;
  localparam int  IW             = rqi_pkg::CFG_IDX_W;
  localparam int  RAND_PER_PHASE = 270;
  localparam int  NUM_PHASES     = 6;
  localparam int  DRAIN_CYCLES   = 120;
  localparam int  CYCLE_LIMIT    = 400000;
  localparam logic [IW-1:0] UNMAPPED_IDX = 4'd12;

  typedef struct {
    logic signed [DW-1:0] st[3];
    logic signed [DW-1:0] dir[3];
  } ray_t;

  typedef struct {
    logic                 found;
    logic signed [DW-1:0] hdist;
    logic signed [DW-1:0] pos[3];
    logic signed [DW-1:0] nrm[3];
  } hit_t;

  // Scoreboard: holds its own copy of the quadric registers and the pending hits
  class hit_scoreboard;
    longint qreg[8];
    hit_t   pending_hits[$];
    int     errors;
    int     rays_seen;
    int     hits_checked;
    int     hits_found;

    function void reset_regs();
      qreg[rqi_pkg::REG_CENTER_X] = 0;
      qreg[rqi_pkg::REG_CENTER_Y] = 0;
      qreg[rqi_pkg::REG_CENTER_Z] = 0;
      qreg[rqi_pkg::REG_COEF_X]   = 64'sd1 <<< FB;
      qreg[rqi_pkg::REG_COEF_Y]   = 64'sd1 <<< FB;
      qreg[rqi_pkg::REG_COEF_Z]   = 64'sd1 <<< FB;
      qreg[rqi_pkg::REG_COEF_K]   = -(64'sd1 <<< FB);
      qreg[rqi_pkg::REG_CLIP_Z]   = (64'sd95 * (64'sd1 <<< FB)) / 100;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
      if (idx < 8) qreg[idx] = longint'(signed'(data));
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Fixed-point product: exact, floor shift, then clamp
    function longint fxmul(longint x, longint y);
      return clamp32((x * y) >>> FB);
    endfunction

    function longint int_sqrt(longint v);
      longint unsigned x, r, b;
      x = v;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function hit_t trace_ray(ray_t r);
      hit_t   h;
      longint st[3], d[3], s[3], p[3];
      longint a, b, c, q, sd, den, t1, t2, t, t_clamp;
      h.found = 1'b0;
      h.hdist = '0;
      for (int i = 0; i < 3; i++) begin
        h.pos[i] = '0;
        h.nrm[i] = '0;
      end
      a = 0;
      b = 0;
      c = 0;
      for (int i = 0; i < 3; i++) begin
        st[i] = r.st[i];
        d[i]  = r.dir[i];
        s[i]  = clamp32(st[i] - qreg[rqi_pkg::REG_CENTER_X + i]);
      end
      for (int i = 0; i < 3; i++) begin
        a += fxmul(qreg[rqi_pkg::REG_COEF_X + i], fxmul(d[i], d[i]));
        b += fxmul(qreg[rqi_pkg::REG_COEF_X + i], fxmul(d[i], s[i]));
        c += fxmul(qreg[rqi_pkg::REG_COEF_X + i], fxmul(s[i], s[i]));
      end
      a = clamp32(a);
      b = clamp32(2 * b);
      c = clamp32(c + qreg[rqi_pkg::REG_COEF_K]);
      // ray along a cylinder axis or degenerate direction
      if (a == 0) return h;
      q = ((b * b) >>> 2) - a * c;
      if (q < 0) return h;
      sd  = 2 * int_sqrt(q);
      den = 2 * a;
      t1  = ((-b + sd) * (64'sd1 <<< FB)) / den;
      t2  = ((-b - sd) * (64'sd1 <<< FB)) / den;
      // both roots behind the origin
      if (t1 <= 0) return h;
      t       = (t2 > 0) ? t2 : t1;
      t_clamp = clamp32(t);
      for (int i = 0; i < 3; i++) p[i] = clamp32(st[i] + ((d[i] * t_clamp) >>> FB));
      if (p[2] > qreg[rqi_pkg::REG_CLIP_Z]) return h;
      h.found = 1'b1;
      h.hdist = t_clamp[DW-1:0];
      for (int i = 0; i < 3; i++) begin
        h.pos[i] = p[i][DW-1:0];
        h.nrm[i] = DW'(clamp32(2 * fxmul(qreg[rqi_pkg::REG_COEF_X + i],
                                         clamp32(p[i] - qreg[rqi_pkg::REG_CENTER_X + i]))));
      end
      return h;
    endfunction

    function void note_ray(ray_t r);
      pending_hits = {pending_hits, trace_ray(r)};
      rays_seen++;
    endfunction

    function void cmp(string name, logic [DW-1:0] exp_v, logic [DW-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
        errors++;
      end
    endfunction

    function void check_hit(hit_t got);
      hit_t e;
      if (pending_hits.size() == 0) begin
        $error("hit request with no ray outstanding");
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      hits_checked++;
      if (e.found) hits_found++;
      cmp("hit_found", DW'(e.found), DW'(got.found));
      cmp("hit_dist", e.hdist, got.hdist);
      cmp("pos_x", e.pos[0], got.pos[0]);
      cmp("pos_y", e.pos[1], got.pos[1]);
      cmp("pos_z", e.pos[2], got.pos[2]);
      cmp("norm_x", e.nrm[0], got.nrm[0]);
      cmp("norm_y", e.nrm[1], got.nrm[1]);
      cmp("norm_z", e.nrm[2], got.nrm[2]);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle = 0;
  int   recv_idle = 0;
  longint cycles = 0;
  hit_scoreboard sb;

  rqi_cfg_if cfg ();
  rqi_ray_if ray ();
  rqi_hit_if hit ();

  ray_quadric_intersect_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .ray_i  (ray),
    .hit_o  (hit)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(negedge clk_i) begin
    hit.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Hit monitor
  always @(posedge clk_i) begin
    hit_t h;
    if (rst_ni && hit.valid && hit.ready) begin
      h.found  = hit.hit_found;
      h.hdist  = hit.hit_dist;
      h.pos[0] = hit.pos_x;
      h.pos[1] = hit.pos_y;
      h.pos[2] = hit.pos_z;
      h.nrm[0] = hit.norm_x;
      h.nrm[1] = hit.norm_y;
      h.nrm[2] = hit.norm_z;
      sb.check_hit(h);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_quadric_intersect_unit_test: errors");
      $finish;
    end
  end

  task automatic cfg_write(logic [IW-1:0] idx, logic [DW-1:0] data);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk_i); while (!cfg.ready);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic send_ray(ray_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      ray.valid = 1'b0;
      @(negedge clk_i);
    end
    ray.valid   = 1'b1;
    ray.start_x = r.st[0];
    ray.start_y = r.st[1];
    ray.start_z = r.st[2];
    ray.dir_x   = r.dir[0];
    ray.dir_y   = r.dir[1];
    ray.dir_z   = r.dir[2];
    do @(posedge clk_i); while (!ray.ready);
    sb.note_ray(r);
  endtask

  // Let the pipeline empty before touching registers
  task automatic drain();
    @(negedge clk_i);
    ray.valid = 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic ray_t mk(longint sx, longint sy, longint sz,
                              longint dx, longint dy, longint dz);
    ray_t r;
    r.st[0]  = sx[31:0];
    r.st[1]  = sy[31:0];
    r.st[2]  = sz[31:0];
    r.dir[0] = dx[31:0];
    r.dir[1] = dy[31:0];
    r.dir[2] = dz[31:0];
    return r;
  endfunction

  // Mostly rays aimed near the center; the rest raw noise
  function automatic ray_t rand_ray();
    ray_t   r;
    longint span, tgt;
    if ($urandom_range(99) < 70) begin
      span = longint'($urandom_range(3)) + 1;
      for (int i = 0; i < 3; i++) begin
        r.st[i] = DW'(sb.qreg[rqi_pkg::REG_CENTER_X + i] +
                      longint'($urandom_range(2 * span * 65536)) - span * 65536);
        tgt = sb.qreg[rqi_pkg::REG_CENTER_X + i] + longint'($urandom_range(131072)) - 65536;
        r.dir[i] = DW'((tgt - longint'(r.st[i])) >>> $urandom_range(2));
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        r.st[i]  = $urandom;
        r.dir[i] = $urandom;
      end
    end
    return r;
  endfunction

  task automatic write_all(longint cx, longint cy, longint cz, longint kx, longint ky,
                           longint kz, longint kc, longint clip);
    cfg_write(rqi_pkg::REG_CENTER_X, cx[31:0]);
    cfg_write(rqi_pkg::REG_CENTER_Y, cy[31:0]);
    cfg_write(rqi_pkg::REG_CENTER_Z, cz[31:0]);
    cfg_write(rqi_pkg::REG_COEF_X, kx[31:0]);
    cfg_write(rqi_pkg::REG_COEF_Y, ky[31:0]);
    cfg_write(rqi_pkg::REG_COEF_Z, kz[31:0]);
    cfg_write(rqi_pkg::REG_COEF_K, kc[31:0]);
    cfg_write(rqi_pkg::REG_CLIP_Z, clip[31:0]);
  endtask

  localparam longint ONE  = 65536;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  initial begin
    ray_t dir_rays[$];
    sb = new();
    sb.reset_regs();
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    ray.valid = 1'b0;
    ray.start_x = '0;
    ray.start_y = '0;
    ray.start_z = '0;
    ray.dir_x = '0;
    ray.dir_y = '0;
    ray.dir_z = '0;
    hit.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rays against the reset unit sphere
    dir_rays = {dir_rays, mk(0, 0, -3 * ONE, 0, 0, ONE)};         // plain hit from below
    dir_rays = {dir_rays, mk(0, 0, 0, 0, 0, 0)};                  // zero leading coefficient
    dir_rays = {dir_rays, mk(2 * ONE, 0, -3 * ONE, 0, 0, ONE)};   // negative discriminant
    dir_rays = {dir_rays, mk(0, 0, 3 * ONE, 0, 0, ONE)};          // both roots behind
    dir_rays = {dir_rays, mk(0, 0, 3 * ONE, 0, 0, -ONE)};         // hit above clip height
    dir_rays = {dir_rays, mk(0, 0, 0, ONE, 0, 0)};                // origin inside
    dir_rays = {dir_rays, mk(ONE, 0, -3 * ONE, 0, 0, ONE)};       // tangent
    dir_rays = {dir_rays, mk(-3 * ONE, ONE / 2, 0, ONE, 0, 0)};   // side hit
    dir_rays = {dir_rays, mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV)};
    dir_rays = {dir_rays, mk(MINV, MINV, MINV, MINV, MINV, MINV)};
    dir_rays = {dir_rays, mk(MAXV, MINV, MAXV, MINV, MAXV, MINV)};
    dir_rays = {dir_rays, mk(MINV, MAXV, MINV, -1, 1, -1)};
    dir_rays = {dir_rays, mk(-1, -1, -1, MAXV, MINV, MAXV)};
    dir_rays = {dir_rays, mk(0, 0, MINV, 0, 0, MAXV)};
    foreach (dir_rays[i]) send_ray(dir_rays[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle = (ph / 2 == 0) ? 27 : (ph / 2 == 1) ? 58 : 0;
      recv_idle = (ph / 2 == 0) ? 58 : (ph / 2 == 1) ? 27 : 0;
      case (ph)
        0: write_all(0, 0, 0, ONE, ONE, ONE, -ONE, 62259);
        1: write_all(ONE / 2, -ONE, ONE / 4, ONE / 4, ONE / 4, ONE / 4, -ONE, 4 * ONE);
        2: write_all(0, ONE, 0, ONE, ONE, 0, -ONE, ONE / 2);          // cylinder along z
        3: write_all(-ONE, 0, 2 * ONE, ONE, -ONE, 2 * ONE, -ONE / 2, MAXV);
        4: begin
          write_all(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV);
          cfg_write(UNMAPPED_IDX, 32'h1234_5678);                   // must be dropped
        end
        default: write_all(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MAXV);
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) send_ray(rand_ray());
      drain();
    end

    $display("Covered %0d rays over %0d register settings; %0d hits, %0d misses checked.",
             sb.rays_seen, NUM_PHASES + 1, sb.hits_found, sb.hits_checked - sb.hits_found);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("ray_quadric_intersect_unit_test: clean");
    end else begin
      $display("ray_quadric_intersect_unit_test: errors");
    end
    $finish;
  end

endmodule
